/* hw/rtl/bttv_pkg.sv */
package bttv_pkg;

    // Field widths of the streams and the configuration port
    localparam int COUNT_BITS = 12;
    localparam int BASE_W     = 3;
    localparam int NSUM_W     = COUNT_BITS + 2;
    localparam int DEPTH_W    = 14;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int IN_BITS    = BASE_W + 4 * COUNT_BITS;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 64 + 2 * DEPTH_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    // Floating-point datapath widths
    localparam int EXP_W = 14;
    localparam int MAN_W = 53;
    localparam int WM_W  = 108;

    localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN = 8'd1;

    // Reference base codes
    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    typedef logic signed [EXP_W-1:0] t_exp;

    // Biased exponent of an integer held in the low mantissa bits
    localparam t_exp INT_EXP = 14'sd1075;

    // Unpacked operand: value = man / 2^52 * 2^(exp - 1023)
    typedef struct packed {
        t_exp             exp;
        logic [MAN_W-1:0] man;
    } t_fp_opnd;

    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_DIV,
        FOP_ADD,
        FOP_SUB
    } t_fpu_op;

    typedef struct packed {
        logic     start;
        t_fpu_op  op;
        t_fp_opnd a;
        t_fp_opnd b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_NORM,
        FS_MUL,
        FS_DIV,
        FS_ADD,
        FS_POST
    } t_fpu_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_PICK1,
        SQ_PICK2,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_DONE
    } t_seq_state;

    typedef enum logic [3:0] {
        SP_P,
        SP_Q,
        SP_R,
        SP_T1,
        SP_T2,
        SP_T3,
        SP_T4,
        SP_U1,
        SP_U2,
        SP_U3,
        SP_U4
    } t_step;

    // Split a non-negative double into exponent and mantissa with hidden bit.
    function automatic t_fp_opnd unpack_dbl(input logic [63:0] bits);
        t_fp_opnd o;
        o.man = {(bits[62:52] != 11'd0), bits[51:0]};
        o.exp = (bits[62:52] == 11'd0) ? 14'sd1 : t_exp'({3'b000, bits[62:52]});
        return o;
    endfunction

    // An unsigned integer as an unnormalised operand.
    function automatic t_fp_opnd int_opnd(input logic [31:0] v);
        t_fp_opnd o;
        o.man = {{(MAN_W-32){1'b0}}, v};
        o.exp = INT_EXP;
        return o;
    endfunction

endpackage

/* hw/rtl/bttv_fpu.sv */
// Shared double-precision unit for non-negative operands: multiply
// (shift and add), divide (restoring), add and subtract, each followed by a
// one-bit-per-cycle normalise and a round-to-nearest-even pack.
module bttv_fpu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bttv_pkg::t_fpu_req  i_req,
    output bttv_pkg::t_fpu_rsp  o_rsp
);

    bttv_pkg::t_fpu_state r_state, n_state;
    bttv_pkg::t_fpu_op    r_op, n_op;
    bttv_pkg::t_exp       r_ae, n_ae, r_be, n_be, r_e, n_e;
    logic [52:0]          r_am, n_am, r_bm, n_bm;
    logic [5:0]           r_cnt, n_cnt;
    logic [105:0]         r_acc, n_acc;
    logic [54:0]          r_rem, n_rem;
    logic [55:0]          r_quo, n_quo;
    logic [107:0]         r_m, n_m;
    logic                 r_done, n_done;
    logic [63:0]          r_res, n_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bttv_pkg::FS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_ae  <= n_ae;
        r_be  <= n_be;
        r_am  <= n_am;
        r_bm  <= n_bm;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_m   <= n_m;
        r_e   <= n_e;
        r_res <= n_res;
    end

    // Sequencing of the operation and the arithmetic of each step
    always_comb begin
        logic           v_an, v_bn, v_swap, v_ge, v_inc;
        logic [53:0]    v_sum, v_mant;
        logic [54:0]    v_rdiff;
        bttv_pkg::t_exp v_xe, v_ye, v_d, v_ep1;
        logic [52:0]    v_xm, v_ym;
        logic [107:0]   v_xw, v_yw, v_ys, v_mask;
        logic [6:0]     v_sh;

        n_state = r_state;
        n_op    = r_op;
        n_ae    = r_ae;
        n_be    = r_be;
        n_am    = r_am;
        n_bm    = r_bm;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_m     = r_m;
        n_e     = r_e;
        n_done  = 1'b0;
        n_res   = r_res;

        v_an    = (r_am != 53'd0) && !r_am[52];
        v_bn    = (r_bm != 53'd0) && !r_bm[52];
        v_sum   = {1'b0, r_acc[105:53]} + (r_bm[0] ? {1'b0, r_am} : 54'd0);
        v_ge    = (r_rem >= {2'b00, r_bm});
        v_rdiff = v_ge ? (r_rem - {2'b00, r_bm}) : r_rem;

        // Alignment for add and subtract: for an add the larger exponent leads, for a subtract the first operand does
        v_swap  = (r_op == bttv_pkg::FOP_ADD) && (r_be > r_ae);
        v_xe    = v_swap ? r_be : r_ae;
        v_ye    = v_swap ? r_ae : r_be;
        v_xm    = v_swap ? r_bm : r_am;
        v_ym    = v_swap ? r_am : r_bm;
        v_d     = v_xe - v_ye;
        v_xw    = {2'b00, v_xm, 53'd0};
        v_yw    = {2'b00, v_ym, 53'd0};
        v_sh    = v_d[6:0];
        v_mask  = ({{(bttv_pkg::WM_W-1){1'b0}}, 1'b1} << v_sh) - 108'd1;
        if (v_d >= 14'sd108) begin
            v_ys = {107'd0, (v_ym != 53'd0)};
        end else begin
            v_ys = (v_yw >> v_sh) | {107'd0, ((v_yw & v_mask) != 108'd0)};
        end

        // Round to nearest even at the 53rd significant bit
        v_inc   = r_m[52] & (r_m[53] | (r_m[51:0] != 52'd0));
        v_mant  = {1'b0, r_m[105:53]} + {53'd0, v_inc};
        v_ep1   = r_e + 14'sd1;

        case (r_state)
            bttv_pkg::FS_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_ae    = i_req.a.exp;
                    n_am    = i_req.a.man;
                    n_be    = i_req.b.exp;
                    n_bm    = i_req.b.man;
                    n_state = bttv_pkg::FS_NORM;
                end
            end
            bttv_pkg::FS_NORM: begin
                // Bring the hidden bit of each non-zero operand to the top
                if (v_an) begin
                    n_am = {r_am[51:0], 1'b0};
                    n_ae = r_ae - 14'sd1;
                end
                if (v_bn) begin
                    n_bm = {r_bm[51:0], 1'b0};
                    n_be = r_be - 14'sd1;
                end
                if (!v_an && !v_bn) begin
                    case (r_op)
                        bttv_pkg::FOP_MUL: begin
                            n_acc   = 106'd0;
                            n_cnt   = 6'd53;
                            n_state = bttv_pkg::FS_MUL;
                        end
                        bttv_pkg::FOP_DIV: begin
                            n_rem   = {2'b00, r_am};
                            n_quo   = 56'd0;
                            n_cnt   = 6'd56;
                            n_state = bttv_pkg::FS_DIV;
                        end
                        default: begin
                            n_state = bttv_pkg::FS_ADD;
                        end
                    endcase
                end
            end
            bttv_pkg::FS_MUL: begin
                // One multiplier bit per cycle, least significant first
                n_acc = {v_sum, r_acc[52:1]};
                n_bm  = {1'b0, r_bm[52:1]};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_m     = {2'b00, v_sum, r_acc[52:1]};
                    n_e     = r_ae + r_be - 14'sd1022;
                    n_state = bttv_pkg::FS_POST;
                end
            end
            bttv_pkg::FS_DIV: begin
                // One quotient bit per cycle; the remainder gives the sticky bit
                n_quo = {r_quo[54:0], v_ge};
                n_rem = {v_rdiff[53:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_m     = {2'b00, r_quo[54:0], v_ge, 49'd0, (v_rdiff != 55'd0)};
                    n_e     = r_ae - r_be + 14'sd1023;
                    n_state = bttv_pkg::FS_POST;
                end
            end
            bttv_pkg::FS_ADD: begin
                n_m     = (r_op == bttv_pkg::FOP_SUB) ? (v_xw - v_ys) : (v_xw + v_ys);
                n_e     = v_xe;
                n_state = bttv_pkg::FS_POST;
            end
            bttv_pkg::FS_POST: begin
                if (r_m == 108'd0) begin
                    n_res   = 64'd0;
                    n_done  = 1'b1;
                    n_state = bttv_pkg::FS_IDLE;
                end else if (r_m[107:106] != 2'b00) begin
                    n_m = {1'b0, r_m[107:2], r_m[1] | r_m[0]};
                    n_e = v_ep1;
                end else if (r_e < -14'sd110) begin
                    // Far below the smallest subnormal: only stickiness remains
                    n_m = {107'd0, 1'b1};
                    n_e = 14'sd1;
                end else if (r_e < 14'sd1) begin
                    n_m = {1'b0, r_m[107:2], r_m[1] | r_m[0]};
                    n_e = v_ep1;
                end else if (!r_m[105] && (r_e > 14'sd1)) begin
                    n_m = {r_m[106:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end else begin
                    if (v_mant[53]) begin
                        n_res = {1'b0, v_ep1[10:0], 52'd0};
                    end else begin
                        n_res = {1'b0, (v_mant[52] ? r_e[10:0] : 11'd0), v_mant[51:0]};
                    end
                    n_done  = 1'b1;
                    n_state = bttv_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = bttv_pkg::FS_IDLE;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

/* hw/rtl/bttv_seq.sv */
// Sequencer that walks the tail sum through the shared floating-point unit.
module bttv_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bttv_pkg::NSUM_W-1:0]       i_n,
    input  logic [bttv_pkg::NSUM_W-1:0]       i_k,
    input  logic [bttv_pkg::RATE_W-1:0]       i_rate_num,
    input  logic [bttv_pkg::RATE_W-1:0]       i_rate_den,
    input  bttv_pkg::t_fpu_rsp                i_rsp,
    output bttv_pkg::t_fpu_req                o_req,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [63:0]                       o_prob
);

    bttv_pkg::t_seq_state            r_state, n_state;
    bttv_pkg::t_step                 r_step, n_step;
    logic [bttv_pkg::NSUM_W-1:0]     r_n, n_n, r_k, n_k, r_rest, n_rest, r_span, n_span;
    logic [bttv_pkg::NSUM_W-1:0]     r_i, n_i, r_j, n_j;
    logic [63:0]                     r_p, n_p, r_q, n_q, r_r, n_r, r_t, n_t, r_sum, n_sum;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bttv_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working values
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_n    <= n_n;
        r_k    <= n_k;
        r_rest <= n_rest;
        r_span <= n_span;
        r_i    <= n_i;
        r_j    <= n_j;
        r_p    <= n_p;
        r_q    <= n_q;
        r_r    <= n_r;
        r_t    <= n_t;
        r_sum  <= n_sum;
    end

    // Next step, operand selection and write-back of unit results
    always_comb begin
        logic [bttv_pkg::NSUM_W-1:0] v_rest;

        n_state = r_state;
        n_step  = r_step;
        n_n     = r_n;
        n_k     = r_k;
        n_rest  = r_rest;
        n_span  = r_span;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        n_q     = r_q;
        n_r     = r_r;
        n_t     = r_t;
        n_sum   = r_sum;
        v_rest  = i_n - i_k;

        o_req.start = 1'b0;
        o_req.op    = bttv_pkg::FOP_MUL;
        o_req.a     = bttv_pkg::unpack_dbl(r_t);
        o_req.b     = bttv_pkg::unpack_dbl(r_p);

        // Operands of the current step
        case (r_step)
            bttv_pkg::SP_P: begin
                o_req.op = bttv_pkg::FOP_DIV;
                o_req.a  = bttv_pkg::int_opnd(32'(i_rate_num));
                o_req.b  = bttv_pkg::int_opnd(32'(i_rate_den));
            end
            bttv_pkg::SP_Q: begin
                o_req.op = bttv_pkg::FOP_SUB;
                o_req.a  = bttv_pkg::unpack_dbl(bttv_pkg::DBL_ONE);
            end
            bttv_pkg::SP_R: begin
                o_req.op = bttv_pkg::FOP_DIV;
                o_req.a  = bttv_pkg::unpack_dbl(r_p);
                o_req.b  = bttv_pkg::unpack_dbl(r_q);
            end
            bttv_pkg::SP_T1: begin
                o_req.op = bttv_pkg::FOP_MUL;
            end
            bttv_pkg::SP_T2: begin
                o_req.b  = bttv_pkg::int_opnd(32'(r_rest + r_i));
            end
            bttv_pkg::SP_T3: begin
                o_req.op = bttv_pkg::FOP_DIV;
                o_req.b  = bttv_pkg::int_opnd(32'(r_i));
            end
            bttv_pkg::SP_T4: begin
                o_req.b  = bttv_pkg::unpack_dbl(r_q);
            end
            bttv_pkg::SP_U1: begin
                o_req.b  = bttv_pkg::int_opnd(32'(r_n - r_j));
            end
            bttv_pkg::SP_U2: begin
                o_req.op = bttv_pkg::FOP_DIV;
                o_req.b  = bttv_pkg::int_opnd(32'(r_j + 1'b1));
            end
            bttv_pkg::SP_U3: begin
                o_req.b  = bttv_pkg::unpack_dbl(r_r);
            end
            bttv_pkg::SP_U4: begin
                o_req.op = bttv_pkg::FOP_ADD;
                o_req.a  = bttv_pkg::unpack_dbl(r_sum);
                o_req.b  = bttv_pkg::unpack_dbl(r_t);
            end
            default: begin
                o_req.op = bttv_pkg::FOP_MUL;
            end
        endcase

        case (r_state)
            bttv_pkg::SQ_IDLE: begin
                if (i_start) begin
                    n_n    = i_n;
                    n_k    = i_k;
                    n_rest = v_rest;
                    n_span = (i_k > v_rest) ? i_k : v_rest;
                    if (i_rate_num >= i_rate_den) begin
                        n_sum   = bttv_pkg::DBL_ONE;
                        n_state = bttv_pkg::SQ_DONE;
                    end else begin
                        n_step  = bttv_pkg::SP_P;
                        n_state = bttv_pkg::SQ_ISSUE;
                    end
                end
            end
            bttv_pkg::SQ_PICK1: begin
                // First term: one index of the product sequence
                if (r_i > r_span) begin
                    n_sum   = r_t;
                    n_j     = r_k;
                    n_state = bttv_pkg::SQ_PICK2;
                end else if (r_i <= r_k) begin
                    n_step  = bttv_pkg::SP_T1;
                    n_state = bttv_pkg::SQ_ISSUE;
                end else begin
                    n_step  = bttv_pkg::SP_T4;
                    n_state = bttv_pkg::SQ_ISSUE;
                end
            end
            bttv_pkg::SQ_PICK2: begin
                // Tail terms by the ratio recurrence, then the clamp to one
                if (r_j < r_n) begin
                    n_step  = bttv_pkg::SP_U1;
                    n_state = bttv_pkg::SQ_ISSUE;
                end else begin
                    n_sum   = (r_sum > bttv_pkg::DBL_ONE) ? bttv_pkg::DBL_ONE : r_sum;
                    n_state = bttv_pkg::SQ_DONE;
                end
            end
            bttv_pkg::SQ_ISSUE: begin
                o_req.start = 1'b1;
                n_state     = bttv_pkg::SQ_WAIT;
            end
            bttv_pkg::SQ_WAIT: begin
                if (i_rsp.done) begin
                    n_state = bttv_pkg::SQ_ISSUE;
                    case (r_step)
                        bttv_pkg::SP_P: begin
                            n_p    = i_rsp.res;
                            n_step = bttv_pkg::SP_Q;
                        end
                        bttv_pkg::SP_Q: begin
                            n_q    = i_rsp.res;
                            n_step = bttv_pkg::SP_R;
                        end
                        bttv_pkg::SP_R: begin
                            n_r     = i_rsp.res;
                            n_t     = bttv_pkg::DBL_ONE;
                            n_i     = {{(bttv_pkg::NSUM_W-1){1'b0}}, 1'b1};
                            n_state = bttv_pkg::SQ_PICK1;
                        end
                        bttv_pkg::SP_T1: begin
                            n_t    = i_rsp.res;
                            n_step = bttv_pkg::SP_T2;
                        end
                        bttv_pkg::SP_T2: begin
                            n_t    = i_rsp.res;
                            n_step = bttv_pkg::SP_T3;
                        end
                        bttv_pkg::SP_T3: begin
                            n_t = i_rsp.res;
                            if (r_i <= r_rest) begin
                                n_step = bttv_pkg::SP_T4;
                            end else begin
                                n_i     = r_i + 1'b1;
                                n_state = bttv_pkg::SQ_PICK1;
                            end
                        end
                        bttv_pkg::SP_T4: begin
                            n_t     = i_rsp.res;
                            n_i     = r_i + 1'b1;
                            n_state = bttv_pkg::SQ_PICK1;
                        end
                        bttv_pkg::SP_U1: begin
                            n_t    = i_rsp.res;
                            n_step = bttv_pkg::SP_U2;
                        end
                        bttv_pkg::SP_U2: begin
                            n_t    = i_rsp.res;
                            n_step = bttv_pkg::SP_U3;
                        end
                        bttv_pkg::SP_U3: begin
                            n_t    = i_rsp.res;
                            n_step = bttv_pkg::SP_U4;
                        end
                        bttv_pkg::SP_U4: begin
                            n_sum   = i_rsp.res;
                            n_j     = r_j + 1'b1;
                            n_state = bttv_pkg::SQ_PICK2;
                        end
                        default: begin
                            n_state = bttv_pkg::SQ_IDLE;
                        end
                    endcase
                end
            end
            bttv_pkg::SQ_DONE: begin
                n_state = bttv_pkg::SQ_IDLE;
            end
            default: begin
                n_state = bttv_pkg::SQ_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != bttv_pkg::SQ_IDLE);
    assign o_done = (r_state == bttv_pkg::SQ_DONE);
    assign o_prob = r_sum;

endmodule

/* hw/rtl/binomial_tail_variant_test_core.sv */
// Binomial upper-tail test for one genome position per transfer. The depth
// N is the sum of the four base counts, K is N less the count of the
// reference base, and the result is P(X >= K) for X ~ Binomial(N, p) with
// p = rate_num / rate_den, as IEEE double bits, together with N and K. A
// single shared double-precision unit does every step: a multiply takes
// one multiplier bit per cycle, a divide one quotient bit per cycle, and
// each operation first shifts out every leading zero of an operand's
// significand, one bit at a time; a result in the subnormal range is
// shifted right further before it is rounded and packed. When rate_num >=
// rate_den the result is one and the unit is not used. The input is not
// ready while an item is in work or while its result waits to be taken.
module binomial_tail_variant_test_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // ref_base, count_a, count_c, count_g, count_t (lowest bits first)
    input  logic [bttv_pkg::IN_W-1:0]         i_s_axis_tdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tail_prob_bits, total_depth, nonref_count (lowest bits first)
    output logic [bttv_pkg::OUT_W-1:0]        o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bttv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bttv_pkg::RATE_W-1:0]       i_cfg_data
);

    localparam int CB = bttv_pkg::COUNT_BITS;

    logic [bttv_pkg::RATE_W-1:0]    r_rate_num, r_rate_den;
    logic                           r_out_valid, n_out_valid;
    logic [63:0]                    r_prob;
    logic [bttv_pkg::NSUM_W-1:0]    r_n, r_k;
    logic                           s_acc, m_acc;
    logic [bttv_pkg::BASE_W-1:0]    base;
    logic [CB-1:0]                  cnt_a, cnt_c, cnt_g, cnt_t, refc;
    logic [bttv_pkg::NSUM_W-1:0]    depth, nonref;
    bttv_pkg::t_fpu_req             fpu_req;
    bttv_pkg::t_fpu_rsp             fpu_rsp;
    logic                           seq_busy, seq_done;
    logic [63:0]                    seq_prob;

    assign s_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid & i_m_axis_tready;

    // Field extraction, depth and non-reference count
    assign base  = i_s_axis_tdata[bttv_pkg::BASE_W-1:0];
    assign cnt_a = i_s_axis_tdata[bttv_pkg::BASE_W + 0*CB +: CB];
    assign cnt_c = i_s_axis_tdata[bttv_pkg::BASE_W + 1*CB +: CB];
    assign cnt_g = i_s_axis_tdata[bttv_pkg::BASE_W + 2*CB +: CB];
    assign cnt_t = i_s_axis_tdata[bttv_pkg::BASE_W + 3*CB +: CB];

    always_comb begin
        case (base)
            bttv_pkg::BASE_A: refc = cnt_a;
            bttv_pkg::BASE_C: refc = cnt_c;
            bttv_pkg::BASE_G: refc = cnt_g;
            bttv_pkg::BASE_T: refc = cnt_t;
            default:          refc = '0;
        endcase
    end

    assign depth  = bttv_pkg::NSUM_W'(cnt_a) + bttv_pkg::NSUM_W'(cnt_c)
                  + bttv_pkg::NSUM_W'(cnt_g) + bttv_pkg::NSUM_W'(cnt_t);
    assign nonref = depth - bttv_pkg::NSUM_W'(refc);

    // Configuration registers; unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num <= 16'd9;
            r_rate_den <= 16'd20000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bttv_pkg::CFG_RATE_NUM) begin
                r_rate_num <= i_cfg_data;
            end else if (i_cfg_index == bttv_pkg::CFG_RATE_DEN) begin
                r_rate_den <= i_cfg_data;
            end
        end
    end

    // Output register: filled when the sequencer finishes, freed on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (seq_done) begin
            n_out_valid = 1'b1;
        end else if (m_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_n <= depth;
            r_k <= nonref;
        end
        if (seq_done) begin
            r_prob <= seq_prob;
        end
    end

    assign o_s_axis_tready = !seq_busy && !r_out_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(bttv_pkg::OUT_W - bttv_pkg::OUT_BITS){1'b0}},
                              bttv_pkg::DEPTH_W'(r_k), bttv_pkg::DEPTH_W'(r_n), r_prob};

    bttv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_acc),
        .i_n        (depth),
        .i_k        (nonref),
        .i_rate_num (r_rate_num),
        .i_rate_den (r_rate_den),
        .i_rsp      (fpu_rsp),
        .o_req      (fpu_req),
        .o_busy     (seq_busy),
        .o_done     (seq_done),
        .o_prob     (seq_prob)
    );

    bttv_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    // A finished result never lands on a result still waiting
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> !r_out_valid)
        else $error("result finished while output register was full");

    // An accepted item starts the sequencer
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> seq_busy)
        else $error("accepted item did not start the sequencer");

    // A finished result is offered in the next cycle
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |=> o_m_axis_tvalid)
        else $error("finished result not offered");

    // A probability never exceeds one
    a_prob_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[63:0] <= bttv_pkg::DBL_ONE))
        else $error("tail probability above one");

endmodule

/* test/binomial_tail_variant_test_core_test.sv */
`timescale 1ns / 1ps

module binomial_tail_variant_test_core_test;

    localparam int          CYCLE_LIMIT = 20_000_000;
    localparam int          QUIET_ITEMS = 200;
    localparam logic [63:0] DBL_ZERO    = 64'h0;
    localparam logic [bttv_pkg::CFG_IDX_W-1:0] CFG_SPARE = bttv_pkg::CFG_RATE_DEN + 8'd1;
    localparam logic [bttv_pkg::BASE_W-1:0]    BASE_OTHER   = 3'd4;
    localparam logic [bttv_pkg::BASE_W-1:0]    BASE_UNK_LO  = 3'd5;
    localparam logic [bttv_pkg::BASE_W-1:0]    BASE_UNK_MID = 3'd6;
    localparam logic [bttv_pkg::BASE_W-1:0]    BASE_UNK_HI  = 3'd7;

    // One expected output transfer
    typedef struct {
        logic [63:0]                  prob;
        logic [bttv_pkg::DEPTH_W-1:0] depth;
        logic [bttv_pkg::DEPTH_W-1:0] nonref;
    } t_tail_result;

    // One row of the directed stimulus table
    typedef struct {
        logic [bttv_pkg::RATE_W-1:0]     num;
        logic [bttv_pkg::RATE_W-1:0]     den;
        logic [bttv_pkg::BASE_W-1:0]     base;
        logic [bttv_pkg::COUNT_BITS-1:0] cnt [4];
        bit                              typed;
        logic [63:0]                     prob;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic [bttv_pkg::IN_W-1:0]         i_s_axis_tdata = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [bttv_pkg::OUT_W-1:0]        o_m_axis_tdata;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [bttv_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [bttv_pkg::RATE_W-1:0]       i_cfg_data = '0;

    t_tail_result                      tail_pending [$];
    logic [bttv_pkg::RATE_W-1:0]       rate_num_q = 16'd9;
    logic [bttv_pkg::RATE_W-1:0]       rate_den_q = 16'd20000;
    int                                failures = 0;
    int unsigned                       cycles = 0;
    bit                                quiet = 1'b0;
    int                                ready_gap = 0;

    binomial_tail_variant_test_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Upper binomial tail, stepped in the same order and rounding as the block.
    function automatic logic [63:0] tail_bits(input int unsigned n, input int unsigned k);
        real p, q, r, t, sum;
        int unsigned rest, span;
        if (rate_num_q >= rate_den_q) return bttv_pkg::DBL_ONE;
        p = real'(rate_num_q) / real'(rate_den_q);
        q = 1.0 - p;
        r = p / q;
        rest = n - k;
        span = (k > rest) ? k : rest;
        t = 1.0;
        for (int unsigned i = 1; i <= span; i++) begin
            if (i <= k) begin
                t = t * p;
                t = t * real'(rest + i);
                t = t / real'(i);
            end
            if (i <= rest) t = t * q;
        end
        sum = t;
        for (int unsigned j = k; j < n; j++) begin
            t = t * real'(n - j);
            t = t / real'(j + 1);
            t = t * r;
            sum = sum + t;
        end
        if (sum > 1.0) sum = 1.0;
        return $realtobits(sum);
    endfunction

    // Cycle counter with the run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver side: ready drops in short bursts until the quiet tail of the run.
    always @(posedge i_clk) begin
        if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
        end else if (!quiet && ($urandom % 5 == 0)) begin
            i_m_axis_tready <= 1'b0;
            ready_gap <= $urandom_range(0, 2);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Each output transfer is checked against the oldest pending result.
    always @(posedge i_clk) begin
        t_tail_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (tail_pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                failures++;
            end else begin
                want = tail_pending.pop_front();
                if (o_m_axis_tdata[63:0] !== want.prob) begin
                    $display("%0t: tail_prob expected %h actual %h", $time, want.prob,
                             o_m_axis_tdata[63:0]);
                    failures++;
                end
                if (o_m_axis_tdata[64 +: bttv_pkg::DEPTH_W] !== want.depth) begin
                    $display("%0t: total_depth expected %0d actual %0d", $time, want.depth,
                             o_m_axis_tdata[64 +: bttv_pkg::DEPTH_W]);
                    failures++;
                end
                if (o_m_axis_tdata[64 + bttv_pkg::DEPTH_W +: bttv_pkg::DEPTH_W]
                    !== want.nonref) begin
                    $display("%0t: nonref_count expected %0d actual %0d", $time,
                             want.nonref,
                             o_m_axis_tdata[64 + bttv_pkg::DEPTH_W +: bttv_pkg::DEPTH_W]);
                    failures++;
                end
            end
        end
    end

    // Wait until every pending result has come out, plus a short margin.
    task automatic drain();
        while (tail_pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // A single register write on the configuration channel.
    task automatic cfg_write(input logic [bttv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bttv_pkg::RATE_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New rate, written while idle; a write to a spare index must be ignored.
    task automatic set_rate(input logic [bttv_pkg::RATE_W-1:0] num,
                            input logic [bttv_pkg::RATE_W-1:0] den);
        // Withdraw the last offered position so it is not taken twice.
        i_s_axis_tvalid <= 1'b0;
        drain();
        cfg_write(bttv_pkg::CFG_RATE_NUM, num);
        cfg_write(bttv_pkg::CFG_RATE_DEN, den);
        if ($urandom % 2) cfg_write(CFG_SPARE + 8'($urandom % 200), 16'($urandom));
        rate_num_q = num;
        rate_den_q = den;
    endtask

    // Offer one position and record its result once the transfer is taken.
    task automatic send_position(input logic [bttv_pkg::BASE_W-1:0] base,
                                 input logic [bttv_pkg::COUNT_BITS-1:0] cnt [4],
                                 input bit typed, input logic [63:0] prob);
        t_tail_result res;
        int unsigned n, refc;
        if (!quiet && ($urandom % 4 == 0)) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tdata  <= bttv_pkg::IN_W'({cnt[3], cnt[2], cnt[1], cnt[0], base});
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        n = cnt[0] + cnt[1] + cnt[2] + cnt[3];
        refc = (base < BASE_OTHER) ? cnt[base] : 0;
        res.depth  = bttv_pkg::DEPTH_W'(n);
        res.nonref = bttv_pkg::DEPTH_W'(n - refc);
        res.prob   = typed ? prob : tail_bits(n, n - refc);
        tail_pending.push_back(res);
    endtask

    // Directed table: rate registers, base, four counts, and a typed answer where obvious.
    function automatic t_row mk(input int num, input int den,
                                input logic [bttv_pkg::BASE_W-1:0] base,
                                input int a, input int c, input int g, input int t,
                                input bit typed, input logic [63:0] prob);
        t_row rw;
        rw.num = bttv_pkg::RATE_W'(num);
        rw.den = bttv_pkg::RATE_W'(den);
        rw.base = base;
        rw.cnt[0] = bttv_pkg::COUNT_BITS'(a);
        rw.cnt[1] = bttv_pkg::COUNT_BITS'(c);
        rw.cnt[2] = bttv_pkg::COUNT_BITS'(g);
        rw.cnt[3] = bttv_pkg::COUNT_BITS'(t);
        rw.typed = typed;
        rw.prob = prob;
        return rw;
    endfunction

    initial begin
        t_row rows [$];
        logic [bttv_pkg::COUNT_BITS-1:0] cnt [4];
        logic [bttv_pkg::BASE_W-1:0] base;
        logic [bttv_pkg::RATE_W-1:0] num, den;
        int total;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk(9, 20000, bttv_pkg::BASE_A, 0, 0, 0, 0, 1, bttv_pkg::DBL_ONE));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_A, 3, 0, 0, 0, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_C, 1, 2, 0, 1, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_G, 0, 1, 3, 0, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_T, 2, 0, 1, 4, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, BASE_OTHER, 1, 1, 1, 0, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, BASE_UNK_LO, 0, 2, 0, 1, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, BASE_UNK_HI, 1, 0, 1, 0, 0, DBL_ZERO));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_A, 20, 5, 3, 2, 0, DBL_ZERO));
        rows.push_back(mk(1, 65535, bttv_pkg::BASE_C, 2, 1, 1, 0, 0, DBL_ZERO));
        rows.push_back(mk(65534, 65535, bttv_pkg::BASE_G, 1, 1, 2, 1, 0, DBL_ZERO));
        rows.push_back(mk(65534, 65535, BASE_UNK_MID, 1, 0, 0, 2, 0, DBL_ZERO));
        rows.push_back(mk(0, 100, bttv_pkg::BASE_A, 0, 2, 0, 0, 1, DBL_ZERO));
        rows.push_back(mk(0, 100, bttv_pkg::BASE_A, 2, 0, 0, 0, 1, bttv_pkg::DBL_ONE));
        rows.push_back(mk(100, 100, bttv_pkg::BASE_T, 4095, 4095, 4095, 4095, 1,
                          bttv_pkg::DBL_ONE));
        rows.push_back(mk(100, 100, BASE_OTHER, 4095, 4095, 4095, 4095, 1,
                          bttv_pkg::DBL_ONE));
        rows.push_back(mk(65535, 65535, BASE_UNK_HI, 4095, 0, 4095, 0, 1,
                          bttv_pkg::DBL_ONE));
        rows.push_back(mk(0, 0, bttv_pkg::BASE_A, 0, 4095, 0, 0, 1, bttv_pkg::DBL_ONE));
        rows.push_back(mk(5, 0, bttv_pkg::BASE_C, 4095, 4095, 0, 0, 1, bttv_pkg::DBL_ONE));
        rows.push_back(mk(7, 3, bttv_pkg::BASE_G, 1, 2, 3, 4, 1, bttv_pkg::DBL_ONE));
        rows.push_back(mk(9, 20000, bttv_pkg::BASE_T, 0, 0, 0, 1, 0, DBL_ZERO));

        foreach (rows[i]) begin
            if (rows[i].num != rate_num_q || rows[i].den != rate_den_q)
                set_rate(rows[i].num, rows[i].den);
            send_position(rows[i].base, rows[i].cnt, rows[i].typed, rows[i].prob);
        end

        // Random phases, each with its own rate setting.
        total = 0;
        while (total < 1900) begin
            case ($urandom % 6)
                0: begin num = 16'd1;     den = 16'd65535; end
                1: begin num = 16'd65534; den = 16'd65535; end
                2: begin num = 16'd0;     den = 16'($urandom_range(1, 65535)); end
                3: begin num = 16'($urandom); den = 16'($urandom_range(0, num)); end
                default: begin
                    den = 16'($urandom_range(2, 65535));
                    num = 16'($urandom_range(1, den - 1));
                end
            endcase
            set_rate(num, den);
            for (int j = 0; j < 190 && total < 1900; j++) begin
                if (total >= 1900 - QUIET_ITEMS) quiet = 1'b1;
                base = 3'($urandom);
                for (int b = 0; b < 4; b++) begin
                    if (rate_num_q >= rate_den_q)
                        cnt[b] = bttv_pkg::COUNT_BITS'($urandom);
                    else
                        cnt[b] = bttv_pkg::COUNT_BITS'($urandom_range(0, 1));
                end
                send_position(base, cnt, 1'b0, DBL_ZERO);
                total++;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* binomial_tail_variant_test_core.f */
hw/rtl/bttv_pkg.sv
hw/rtl/bttv_fpu.sv
hw/rtl/bttv_seq.sv
hw/rtl/binomial_tail_variant_test_core.sv
test/binomial_tail_variant_test_core_test.sv
